// ===== src/polyphase_fir_resampler_defines.svh =====
// assertion macros shared by the resampler checker
`ifndef POLYPHASE_FIR_RESAMPLER_DEFINES_SVH
`define POLYPHASE_FIR_RESAMPLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("resampler check failed");

// next-cycle implication, disabled in reset
`define PFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("resampler check failed");

`endif

// ===== src/pfr_pkg.sv =====
// shared constants for the polyphase resampler
package pfr_pkg;

    // parameter defaults
    localparam int DEF_MAX_SAMPLES     = 4096;
    localparam int DEF_MAX_TAPS        = 64;
    localparam int DEF_MAX_LOG2_PHASES = 6;

    // fixed-point layout
    localparam int FRAC_BITS  = 16;
    localparam int RATE_W     = 20;
    localparam int POS_W      = 48;
    localparam int ACC_W      = 40;
    localparam int OUT_SHIFT  = 15;
    localparam int SAMPLE_W   = 16;
    localparam int CIDX_W     = 13;

    // saturation bounds
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

    // request codes
    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_LOAD    = 2'd1;
    localparam logic [1:0] FUNC_COEF    = 2'd2;
    localparam logic [1:0] FUNC_PRODUCE = 2'd3;

    // register indexes
    localparam logic [2:0] REG_IN_RATE     = 3'd0;
    localparam logic [2:0] REG_OUT_RATE    = 3'd1;
    localparam logic [2:0] REG_LOG2_PHASES = 3'd2;
    localparam logic [2:0] REG_TAPS        = 3'd3;
    localparam logic [2:0] REG_OUT_LENGTH  = 3'd4;

    // register reset values
    localparam logic [RATE_W-1:0] RST_IN_RATE    = 20'd48000;
    localparam logic [RATE_W-1:0] RST_OUT_RATE   = 20'd48000;
    localparam logic [2:0]        RST_LOG2       = 3'd6;
    localparam logic [6:0]        RST_TAPS       = 7'd64;
    localparam logic [RATE_W-1:0] RST_OUT_LENGTH = 20'd1024;

    // divider result handed to the top level
    typedef struct packed {
        logic                  done;
        logic [RATE_W-1:0]     rem;
    } pfr_div_stat_t;

endpackage

// ===== src/pfr_divider.sv =====
// restoring divider, one quotient bit per cycle
module pfr_divider
    import pfr_pkg::*;
#(
    parameter int NUM_W = 42
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [RATE_W-1:0] den,
    output logic [NUM_W-1:0]  quot,
    output pfr_div_stat_t     stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  work_reg, work_next;
    logic [RATE_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W:0]   trial;

    // shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg[RATE_W-1:0], work_reg[NUM_W-1]};
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next  = trial - {1'b0, den};
                work_next = {work_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                work_next = {work_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign quot      = work_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg[RATE_W-1:0];

endmodule

// ===== src/polyphase_fir_resampler.sv =====
// Mono 16-bit polyphase FIR resampler with interpolated coefficients.
//
// Input channel s_*: one request per transfer (clear, load sample, write
// coefficient, produce). Load and coefficient writes leave the block idle.
// A clear runs the step division through a bit-serial divider when
// out_rate is nonzero. A produce walks the taps with one shared
// multiply-accumulate pipeline, one tap a cycle, fed by the sample memory
// and a two-read coefficient memory. One request is worked at a time;
// s_tready is low during a produce and while the divider runs.
// Output channel m_*: one result per produce, held in an output register;
// a new request is taken while it waits. If the receiver stalls, the next
// produce finishes its sum and then holds until the waiting result is taken.
// Config channel cfg_*: always ready; write only while the block is idle.
// Reset sets the registers to their defaults and clears position, counts
// and step; the sample and coefficient memories hold stale data until written.
module polyphase_fir_resampler
    import pfr_pkg::*;
#(
    parameter int MAX_SAMPLES     = DEF_MAX_SAMPLES,
    parameter int MAX_TAPS        = DEF_MAX_TAPS,
    parameter int MAX_LOG2_PHASES = DEF_MAX_LOG2_PHASES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,    // func[1:0], sample[17:2], coef_index[30:18]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,    // out_sample[15:0]
    output logic [0:0]        m_tuser,    // clipped[0]
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    localparam int SAW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = SAW + 1;
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int FW     = (MAX_LOG2_PHASES > 0) ? MAX_LOG2_PHASES : 1;
    localparam int CDEPTH = MAX_TAPS * ((1 << MAX_LOG2_PHASES) + 1);
    localparam int CAW    = $clog2(CDEPTH);
    localparam int NUM_W  = RATE_W + MAX_LOG2_PHASES + FRAC_BITS;
    localparam int BASE_W = POS_W - FRAC_BITS;
    localparam int IDX_W  = BASE_W + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // request fields
    logic [1:0]          in_func;
    logic [SAMPLE_W-1:0] in_sample;
    logic [CIDX_W-1:0]   in_cidx;
    assign in_func   = s_tdata[1:0];
    assign in_sample = s_tdata[17:2];
    assign in_cidx   = s_tdata[30:18];

    // configuration registers
    logic [RATE_W-1:0] in_rate_reg, out_rate_reg, out_length_reg;
    logic [2:0]        log2_reg;
    logic [6:0]        taps_reg;

    // run state
    logic [2:0]        state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [POS_W-1:0]  pos_whole_reg;
    logic [RATE_W-1:0] pos_rem_reg;
    logic [POS_W-1:0]  step_whole_reg;
    logic [RATE_W-1:0] step_rem_reg;
    logic [RATE_W-1:0] oidx_reg;

    // tap walk
    logic signed [IDX_W-1:0] idx_reg;
    logic [CAW-1:0]          a0_reg, a1_reg;
    logic [TW-1:0]           j_reg;
    logic [15:0]             ff1_reg;
    logic [16:0]             ff0_reg;

    // output register
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic                m_clip_reg, m_last_reg;

    logic accept, out_take;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_take  = m_valid_reg && m_tready;

    // effective phase order and tap count
    logic [2:0]    b_eff;
    logic [TW-1:0] n_eff;
    assign b_eff = (32'(log2_reg) > MAX_LOG2_PHASES) ? 3'(MAX_LOG2_PHASES) : log2_reg;
    assign n_eff = (32'(taps_reg) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_reg);

    // setup values for a produce
    logic [BASE_W-1:0] base_w;
    logic [FW-1:0]     fn_w;
    logic [CAW-1:0]    a0_w;
    assign base_w = BASE_W'(pos_whole_reg >> (6'(FRAC_BITS) + 6'(b_eff)));
    assign fn_w   = FW'((pos_whole_reg >> FRAC_BITS) & ((POS_W'(1) << b_eff) - POS_W'(1)));
    assign a0_w   = CAW'(fn_w * n_eff);

    // step division
    logic [NUM_W-1:0] div_num, div_quot;
    pfr_div_stat_t    div_stat;
    logic             div_start;
    assign div_num   = NUM_W'(in_rate_reg) << (6'(FRAC_BITS) + 6'(b_eff));
    assign div_start = accept && (in_func == FUNC_CLEAR) && (out_rate_reg != '0);

    pfr_divider #(.NUM_W(NUM_W)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (out_rate_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // tap issue
    logic issue, in_range;
    assign issue    = (state_reg == ST_MAC) && (j_reg != n_eff);
    assign in_range = !idx_reg[IDX_W-1]
                      && (idx_reg[IDX_W-2:0] < (IDX_W-1)'(count_reg));

    // sample memory, one write and one registered read
    logic [SAMPLE_W-1:0] smem [MAX_SAMPLES];
    logic                s_we;
    logic signed [SAMPLE_W-1:0] s_rd;
    assign s_we = accept && (in_func == FUNC_LOAD) && (32'(count_reg) < MAX_SAMPLES);

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[count_reg[SAW-1:0]] <= in_sample;
        end
        s_rd <= smem[idx_reg[SAW-1:0]];
    end

    // coefficient memory, one write and two registered reads
    // writes only happen while idle; reads are not gated and matter only during a produce
    logic [SAMPLE_W-1:0] cmem [CDEPTH];
    logic                c_we;
    logic signed [SAMPLE_W-1:0] c0_rd, c1_rd;
    assign c_we = accept && (in_func == FUNC_COEF) && (32'(in_cidx) < CDEPTH);

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cmem[CAW'(in_cidx)] <= in_sample;
        end
        c0_rd <= cmem[a0_reg];
        c1_rd <= cmem[a1_reg];
    end

    // multiply-accumulate pipeline
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [33:0]         p0_reg, p1_reg;
    logic signed [SAMPLE_W-1:0] s2_reg, s3_reg;
    logic signed [18:0]         f_reg;
    logic signed [34:0]         prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [34:0]         mix_sum;
    assign mix_sum = 35'(p0_reg) + 35'(p1_reg);

    always_ff @(posedge clk)
    begin
        p0_reg   <= c0_rd * $signed({1'b0, ff0_reg});
        p1_reg   <= c1_rd * $signed({2'b0, ff1_reg});
        s2_reg   <= s_rd;
        f_reg    <= mix_sum[34:16];
        s3_reg   <= s2_reg;
        prod_reg <= s3_reg * f_reg;
    end

    // final scaling and saturation
    logic signed [ACC_W-OUT_SHIFT-1:0] acc_sh;
    logic signed [SAMPLE_W-1:0]        sat_val;
    logic                              sat_clip;
    assign acc_sh = acc_reg[ACC_W-1:OUT_SHIFT];

    always_comb
    begin
        sat_clip = 1'b1;
        if (acc_sh > (ACC_W-OUT_SHIFT)'(SAT_MAX))
        begin
            sat_val = SAT_MAX;
        end
        else if (acc_sh < (ACC_W-OUT_SHIFT)'(SAT_MIN))
        begin
            sat_val = SAT_MIN;
        end
        else
        begin
            sat_val  = acc_sh[SAMPLE_W-1:0];
            sat_clip = 1'b0;
        end
    end

    // position advance
    logic [RATE_W:0]   rem_sum;
    logic              rem_wrap;
    logic [RATE_W-1:0] oidx_next;
    assign rem_sum   = {1'b0, pos_rem_reg} + {1'b0, step_rem_reg};
    assign rem_wrap  = rem_sum >= {1'b0, out_rate_reg};
    assign oidx_next = oidx_reg + 1'b1;

    logic fin_go;
    assign fin_go = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg    <= RST_IN_RATE;
            out_rate_reg   <= RST_OUT_RATE;
            log2_reg       <= RST_LOG2;
            taps_reg       <= RST_TAPS;
            out_length_reg <= RST_OUT_LENGTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IN_RATE:     in_rate_reg    <= cfg_data;
                REG_OUT_RATE:    out_rate_reg   <= cfg_data;
                REG_LOG2_PHASES: log2_reg       <= cfg_data[2:0];
                REG_TAPS:        taps_reg       <= cfg_data[6:0];
                REG_OUT_LENGTH:  out_length_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pos_whole_reg  <= '0;
            pos_rem_reg    <= '0;
            step_whole_reg <= '0;
            step_rem_reg   <= '0;
            oidx_reg       <= '0;
            j_reg          <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= issue && in_range;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            // a finished sum refills the output register as the old one leaves
            if (fin_go)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_func)
                            FUNC_CLEAR:
                            begin
                                pos_whole_reg  <= '0;
                                pos_rem_reg    <= '0;
                                count_reg      <= '0;
                                oidx_reg       <= '0;
                                step_whole_reg <= '0;
                                step_rem_reg   <= '0;
                                if (out_rate_reg != '0)
                                begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            FUNC_LOAD:
                            begin
                                if (s_we)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            FUNC_PRODUCE:
                            begin
                                j_reg     <= '0;
                                state_reg <= ST_MAC;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        step_whole_reg <= POS_W'(div_quot);
                        step_rem_reg   <= div_stat.rem;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_MAC:
                begin
                    if (issue)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        oidx_reg <= oidx_next;
                        if (rem_wrap)
                        begin
                            pos_rem_reg   <= RATE_W'(rem_sum - {1'b0, out_rate_reg});
                            pos_whole_reg <= pos_whole_reg + step_whole_reg + 1'b1;
                        end
                        else
                        begin
                            pos_rem_reg   <= rem_sum[RATE_W-1:0];
                            pos_whole_reg <= pos_whole_reg + step_whole_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // tap walk datapath and accumulator
    always_ff @(posedge clk)
    begin
        if (accept && (in_func == FUNC_PRODUCE))
        begin
            idx_reg <= $signed({2'b0, base_w}) - $signed(IDX_W'(n_eff >> 1));
            a0_reg  <= a0_w;
            a1_reg  <= a0_w + CAW'(n_eff);
            ff1_reg <= pos_whole_reg[FRAC_BITS-1:0];
            ff0_reg <= 17'h10000 - {1'b0, pos_whole_reg[FRAC_BITS-1:0]};
            acc_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
                a0_reg  <= a0_reg + 1'b1;
                a1_reg  <= a1_reg + 1'b1;
            end
            if (v4_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        if (fin_go)
        begin
            m_data_reg <= sat_val;
            m_clip_reg <= sat_clip;
            m_last_reg <= (oidx_next == out_length_reg);
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_clip_reg;
    assign m_tlast    = m_last_reg;

endmodule

// ===== src/pfr_checker.sv =====
// port-level checks for the resampler, bound to the top level
`include "polyphase_fir_resampler_defines.svh"

module pfr_checker
    import pfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    `PFR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // a produce transfer occupies the block
    `PFR_ASSERT_NEXT(a_produce_busy, clk, rst_n, s_tvalid && s_tready && (s_tdata[1:0] == FUNC_PRODUCE), !s_tready)

    // a clipped result sits on a rail
    `PFR_ASSERT_NOW(a_clip_rail, clk, rst_n, m_tvalid && m_tuser[0], (m_tdata == 16'h7fff) || (m_tdata == 16'h8000))

endmodule

bind polyphase_fir_resampler pfr_checker u_pfr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/testbench.sv =====
// self-checking testbench for the polyphase fir resampler
module testbench;
    import pfr_pkg::*;

    localparam int SAMPLE_DEPTH = DEF_MAX_SAMPLES;
    localparam int COEF_ENTRIES = DEF_MAX_TAPS * ((1 << DEF_MAX_LOG2_PHASES) + 1);
    localparam int COEF_USED = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [15:0] level;
        logic        clip;
        logic        last;
    } resampled_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [RATE_W-1:0] cfg_data;

    // register copies
    logic [19:0] in_rate_q;
    logic [19:0] out_rate_q;
    logic [2:0]  log2_q;
    logic [6:0]  taps_q;
    logic [19:0] out_len_q;

    // resampler state copies
    shortint     sample_mem [SAMPLE_DEPTH];
    shortint     coef_mem [COEF_ENTRIES];
    int          sample_cnt;
    logic [47:0] pos_whole;
    logic [19:0] pos_rem;
    logic [47:0] step_whole;
    logic [19:0] step_rem;
    logic [19:0] out_idx;

    resampled_t  pending_outputs[$];
    int          error_cnt;
    int          outputs_seen;
    int          clips_seen;
    int          lasts_seen;
    int          requests_sent;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;

    polyphase_fir_resampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        resampled_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            outputs_seen = outputs_seen + 1;
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected result transfer: out_sample %0d", $signed(m_tdata));
                error_cnt = error_cnt + 1;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (want.clip)
                    clips_seen = clips_seen + 1;
                if (want.last)
                    lasts_seen = lasts_seen + 1;
                if (m_tdata !== want.level)
                begin
                    $error("out_sample: expected %0d actual %0d",
                           $signed(want.level), $signed(m_tdata));
                    error_cnt = error_cnt + 1;
                end
                if (m_tuser[0] !== want.clip)
                begin
                    $error("clipped: expected %0b actual %0b", want.clip, m_tuser[0]);
                    error_cnt = error_cnt + 1;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_output: expected %0b actual %0b", want.last, m_tlast);
                    error_cnt = error_cnt + 1;
                end
            end
        end
    end

    // one fir output from the current position
    function automatic resampled_t filter_output();
        resampled_t r;
        int         b;
        int         n;
        longint     fn;
        longint     ff1;
        longint     ff0;
        longint     off;
        longint     acc;
        longint     idx;
        longint     c0;
        longint     c1;
        longint     f;
        longint     a0;
        longint     a1;
        b = (log2_q > 6) ? 6 : int'(log2_q);
        n = (taps_q > 64) ? 64 : int'(taps_q);
        fn = longint'((pos_whole >> 16) & ((48'd1 << b) - 48'd1));
        ff1 = longint'(pos_whole[15:0]);
        ff0 = 65536 - ff1;
        off = longint'(pos_whole >> (16 + b)) - (n / 2);
        acc = 0;
        for (int j = 0; j < n; j++)
        begin
            idx = off + j;
            if (idx >= 0 && idx < sample_cnt)
            begin
                a0 = fn * n + j;
                a1 = (fn + 1) * n + j;
                c0 = (a0 < COEF_ENTRIES) ? coef_mem[a0] : 0;
                c1 = (a1 < COEF_ENTRIES) ? coef_mem[a1] : 0;
                f = (c0 * ff0 + c1 * ff1) >>> 16;
                acc = acc + longint'(sample_mem[idx]) * f;
            end
        end
        acc = acc >>> 15;
        r.clip = 1'b0;
        if (acc > 32767)
        begin
            acc = 32767;
            r.clip = 1'b1;
        end
        else if (acc < -32768)
        begin
            acc = -32768;
            r.clip = 1'b1;
        end
        r.level = acc[15:0];
        return r;
    endfunction

    // advance the resampler copy by one accepted request
    task automatic apply_request(input logic [1:0] func, input logic [15:0] value,
                                 input logic [12:0] cidx);
        resampled_t  r;
        longint      num;
        logic [20:0] rem_sum;
        int          b;
        case (func)
            FUNC_CLEAR:
            begin
                b = (log2_q > 6) ? 6 : int'(log2_q);
                num = longint'(in_rate_q) << (b + 16);
                if (out_rate_q != 0)
                begin
                    step_whole = 48'(num / out_rate_q);
                    step_rem = 20'(num % out_rate_q);
                end
                else
                begin
                    step_whole = '0;
                    step_rem = '0;
                end
                pos_whole = '0;
                pos_rem = '0;
                sample_cnt = 0;
                out_idx = '0;
            end
            FUNC_LOAD:
            begin
                if (sample_cnt < SAMPLE_DEPTH)
                begin
                    sample_mem[sample_cnt] = value;
                    sample_cnt = sample_cnt + 1;
                end
            end
            FUNC_COEF:
            begin
                if (cidx < COEF_ENTRIES)
                    coef_mem[cidx] = value;
            end
            default:
            begin
                r = filter_output();
                out_idx = out_idx + 20'd1;
                r.last = (out_idx == out_len_q);
                pending_outputs.push_back(r);
                rem_sum = {1'b0, pos_rem} + {1'b0, step_rem};
                pos_whole = pos_whole + step_whole;
                if (rem_sum >= {1'b0, out_rate_q})
                begin
                    rem_sum = rem_sum - {1'b0, out_rate_q};
                    pos_whole = pos_whole + 48'd1;
                end
                pos_rem = rem_sum[19:0];
            end
        endcase
    endtask

    // drive one request and wait for its transfer
    task automatic send_request(input logic [1:0] func, input logic [15:0] value,
                                input logic [12:0] cidx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, cidx, value, func};
        do
            @(posedge clk);
        while (!s_tready);
        apply_request(func, value, cidx);
        requests_sent = requests_sent + 1;
    endtask

    // stop sending and wait for every predicted result
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IN_RATE:     in_rate_q = data;
            REG_OUT_RATE:    out_rate_q = data;
            REG_LOG2_PHASES: log2_q = data[2:0];
            REG_TAPS:        taps_q = data[6:0];
            REG_OUT_LENGTH:  out_len_q = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input int ir, input int orate, input int lg, input int tp,
                              input int ol);
        write_reg(REG_IN_RATE, 20'(ir));
        write_reg(REG_OUT_RATE, 20'(orate));
        write_reg(REG_LOG2_PHASES, 20'(lg));
        write_reg(REG_TAPS, 20'(tp));
        write_reg(REG_OUT_LENGTH, 20'(ol));
    endtask

    // low part of the coefficient table; every setting used reads only there
    task automatic test_coefficient_table();
        for (int i = 0; i < COEF_USED; i++)
            send_request(FUNC_COEF, 16'($urandom_range(0, 65535)), 13'(i));
        // indexes past the table are ignored
        send_request(FUNC_COEF, 16'h7fff, 13'(COEF_ENTRIES));
        send_request(FUNC_COEF, 16'h8000, 13'h1fff);
    endtask

    // extremes, clipping both ways, run end and odd register values
    task automatic test_directed();
        set_config(1, 1, 0, 4, 2);
        for (int i = 0; i < 8; i++)
            send_request(FUNC_COEF, 16'h7fff, 13'(i));
        send_request(FUNC_CLEAR, 16'h0, 13'h0);
        send_request(FUNC_LOAD, 16'h7fff, 13'h0);
        send_request(FUNC_LOAD, 16'h7fff, 13'h0);
        send_request(FUNC_LOAD, 16'h7fff, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        send_request(FUNC_LOAD, 16'h8000, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        for (int i = 0; i < 8; i++)
            send_request(FUNC_COEF, 16'h8000, 13'(i));
        send_request(FUNC_CLEAR, 16'h0, 13'h0);
        send_request(FUNC_LOAD, 16'h7fff, 13'h0);
        send_request(FUNC_LOAD, 16'h7fff, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        // zero out_rate steps one position unit per output
        set_config(1048575, 0, 7, 127, 0);
        send_request(FUNC_CLEAR, 16'h0, 13'h0);
        send_request(FUNC_LOAD, 16'h1234, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        // zero taps gives an empty sum
        set_config(1048575, 1, 6, 0, 1048575);
        send_request(FUNC_CLEAR, 16'h0, 13'h0);
        send_request(FUNC_LOAD, 16'h7fff, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
        send_request(FUNC_PRODUCE, 16'h0, 13'h0);
    endtask

    // walk the filter window past the end of the loaded samples
    task automatic test_store_edge();
        set_config(10, 1, 0, 64, 5);
        send_request(FUNC_CLEAR, 16'h0, 13'h0);
        for (int i = 0; i < 40; i++)
            send_request(FUNC_LOAD, 16'($urandom_range(0, 65535)), 13'h0);
        for (int i = 0; i < 6; i++)
            send_request(FUNC_PRODUCE, 16'h0, 13'h0);
    endtask

    // random runs over several register settings
    task automatic test_random_runs();
        int orate;
        int irate;
        int tp;
        int pick;
        for (int ph = 0; ph < 8; ph++)
        begin
            orate = $urandom_range(1000, 1048575);
            irate = orate / 2 + $urandom_range(0, orate + orate / 2);
            if (irate > 1048575)
                irate = 1048575;
            tp = ($urandom_range(3) == 0) ? 28 : $urandom_range(1, 16);
            set_config(irate, orate, $urandom_range(0, 3), tp, $urandom_range(1, 20));
            // quiet stretch in one phase
            send_idle_pct = (ph == 3) ? 0 : 16;
            recv_stall_pct = (ph == 3) ? 0 : 16;
            send_request(FUNC_CLEAR, 16'h0, 13'h0);
            for (int i = 0; i < 60; i++)
            begin
                pick = $urandom_range(99);
                if (i == 30 && ph == 5)
                    drain_outputs();
                if (pick < 55)
                    send_request(FUNC_LOAD, 16'($urandom_range(0, 65535)), 13'h0);
                else if (pick < 90)
                    send_request(FUNC_PRODUCE, 16'($urandom_range(0, 65535)),
                                 13'($urandom_range(0, 8191)));
                else if (pick < 96)
                    send_request(FUNC_COEF, 16'($urandom_range(0, 65535)),
                                 13'($urandom_range(0, 8191)));
                else
                    send_request(FUNC_CLEAR, 16'($urandom_range(0, 65535)),
                                 13'($urandom_range(0, 8191)));
            end
        end
        send_idle_pct = 16;
        recv_stall_pct = 16;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_cnt = 0;
        error_cnt = 0;
        outputs_seen = 0;
        clips_seen = 0;
        lasts_seen = 0;
        requests_sent = 0;
        send_idle_pct = 16;
        recv_stall_pct = 16;
        in_rate_q = RST_IN_RATE;
        out_rate_q = RST_OUT_RATE;
        log2_q = RST_LOG2;
        taps_q = RST_TAPS;
        out_len_q = RST_OUT_LENGTH;
        sample_cnt = 0;
        pos_whole = '0;
        pos_rem = '0;
        step_whole = '0;
        step_rem = '0;
        out_idx = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coefficient_table();
        test_directed();
        test_store_edge();
        test_random_runs();

        drain_outputs();
        $display("covered %0d requests, %0d outputs, %0d clipped, %0d run ends",
                 requests_sent, outputs_seen, clips_seen, lasts_seen);
        $display("register settings included zero out_rate, zero taps and oversize values");
        if (error_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pfr_pkg.sv
src/pfr_divider.sv
src/polyphase_fir_resampler.sv
src/pfr_checker.sv
test/testbench.sv
